// ----- rtl/core/line_editor_field_tokenizer_core_defines.svh -----
// Assertion macros for the line editor and field tokenizer core.
// Included by rtl files that carry concurrent checks; no other dependencies.
`ifndef LINE_EDITOR_FIELD_TOKENIZER_CORE_DEFINES_SVH
`define LINE_EDITOR_FIELD_TOKENIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LEFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LEFT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LEFT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LEFT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/left_pkg.sv -----
// Shared constants, result kinds and character classes for the line editor core.
// No dependencies.
package left_pkg;

  localparam int LINE_CHARS  = 80;
  localparam int FIELD_SLOTS = 8;
  localparam int IDX_W       = $clog2(LINE_CHARS);

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CARET  = 8'h5E;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_numchar(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || c == CH_MINUS || c == CH_DOT;
  endfunction

endpackage

// ----- rtl/core/left_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module left_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/line_editor_field_tokenizer_core.sv -----
// Line editor and field tokenizer, top level.
// Uses left_pkg, left_ram and the assertion macros in the defines header.
`include "line_editor_field_tokenizer_core_defines.svh"

// One received character per input beat. Ordinary keystrokes give one echo beat
// and the next character can be taken in the cycle after if the echo is not held
// by output back-pressure. LF, CR or a full line (LINE_CHARS-1 stored characters)
// starts a scan of the line RAM: each stored character passes a read issue state
// and then a classify state on the registered read data of the single read port,
// waiting on output back-pressure. The scan gives one field record per field and
// then an end record with the field total. The line RAM needs no clearing after
// reset; only positions below the write index are ever read.
module line_editor_field_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] echo_char, [10:8] field_slot,
                                  // [17:11] field_start, [18] field_numeric,
                                  // [24:19] field_total, [25] overflow, rest zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);
  import left_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_END   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] scan_i_r, scan_i_nxt;
  logic             letter_r, letter_nxt;
  logic             digit_r, digit_nxt;
  logic             refused_r, refused_nxt;
  logic             in_field_r, in_field_nxt;
  logic             ovf_r, ovf_nxt;
  logic [5:0]       total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_data_r, out_data_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic             out_last_r, out_last_nxt;

  logic             ram_we;
  logic [7:0]       ram_rdata;
  logic             out_free;
  logic             in_acc;
  logic [7:0]       c;
  logic             rd_field;
  logic             scan_done;

  left_ram #(.WIDTH(8), .DEPTH(LINE_CHARS)) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (c),
    .raddr (scan_i_r),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign c         = in_tdata;
  assign rd_field  = is_letter(ram_rdata) || is_numchar(ram_rdata);
  assign scan_done = (IDX_W'(scan_i_r + 1'b1) == wr_idx_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    scan_i_nxt    = scan_i_r;
    letter_nxt    = letter_r;
    digit_nxt     = digit_r;
    refused_nxt   = refused_r;
    in_field_nxt  = in_field_r;
    ovf_nxt       = ovf_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (wr_idx_r == IDX_W'(LINE_CHARS - 1) || c == CH_LF || c == CH_CR) begin
            // line end: scan whatever is stored
            ovf_nxt      = (wr_idx_r == IDX_W'(LINE_CHARS - 1));
            scan_i_nxt   = '0;
            total_nxt    = '0;
            in_field_nxt = 1'b0;
            state_nxt    = (wr_idx_r == '0) ? ST_END : ST_READ;
          end else if (c == CH_BS || c == CH_DEL) begin
            if (wr_idx_r != '0) begin
              if (!refused_r) begin
                wr_idx_nxt = wr_idx_r - 1'b1;
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = {24'd0, c};
              out_kind_nxt  = KIND_ECHO;
              out_last_nxt  = 1'b1;
            end
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_ECHO;
            out_last_nxt  = 1'b1;
            out_data_nxt  = {24'd0, c};
            if (c == CH_SPACE || c == CH_COMMA) begin
              ram_we      = 1'b1;
              wr_idx_nxt  = wr_idx_r + 1'b1;
              letter_nxt  = 1'b0;
              digit_nxt   = 1'b0;
              refused_nxt = 1'b0;
            end else if (is_letter(c)) begin
              if (!digit_r) begin
                ram_we      = 1'b1;
                wr_idx_nxt  = wr_idx_r + 1'b1;
                letter_nxt  = 1'b1;
                refused_nxt = 1'b0;
              end else begin
                refused_nxt  = 1'b1;
                out_data_nxt = {24'd0, CH_STAR};
              end
            end else if (is_numchar(c)) begin
              if (!letter_r) begin
                ram_we      = 1'b1;
                wr_idx_nxt  = wr_idx_r + 1'b1;
                digit_nxt   = 1'b1;
                refused_nxt = 1'b0;
              end else begin
                refused_nxt  = 1'b1;
                out_data_nxt = {24'd0, CH_STAR};
              end
            end else begin
              refused_nxt  = 1'b1;
              out_data_nxt = {24'd0, CH_CARET};
            end
          end
        end
      end
      ST_READ: begin
        // read address is scan_i_r, data valid next cycle
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (rd_field && !in_field_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_FIELD;
            out_last_nxt  = 1'b0;
            out_data_nxt  = {13'd0, is_numchar(ram_rdata), 7'(scan_i_r),
                             3'(total_r % FIELD_SLOTS), 8'd0};
            total_nxt     = total_r + 1'b1;
            in_field_nxt  = 1'b1;
            scan_i_nxt    = scan_i_r + 1'b1;
            state_nxt     = scan_done ? ST_END : ST_READ;
          end
        end else begin
          in_field_nxt = rd_field;
          scan_i_nxt   = scan_i_r + 1'b1;
          state_nxt    = scan_done ? ST_END : ST_READ;
        end
      end
      ST_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_END;
          out_last_nxt  = 1'b1;
          out_data_nxt  = {6'd0, ovf_r, total_r, 19'd0};
          wr_idx_nxt    = '0;
          letter_nxt    = 1'b0;
          digit_nxt     = 1'b0;
          refused_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_idx_r    <= '0;
      letter_r    <= 1'b0;
      digit_r     <= 1'b0;
      refused_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      letter_r    <= letter_nxt;
      digit_r     <= digit_nxt;
      refused_r   <= refused_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_i_r   <= scan_i_nxt;
    in_field_r <= in_field_nxt;
    ovf_r      <= ovf_nxt;
    total_r    <= total_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  // write index never passes the overflow point
  `LEFT_ASSERT_IMP(a_wr_idx_range, clk, rst_n, 1'b1, wr_idx_r <= IDX_W'(LINE_CHARS - 1))
  // scan stays inside the stored characters
  `LEFT_ASSERT_IMP(a_scan_range, clk, rst_n, state_r == ST_CHECK, scan_i_r < wr_idx_r)
  // end record always closes the beat train of a line
  `LEFT_ASSERT_IMP(a_end_last, clk, rst_n, out_valid_r && out_kind_r == KIND_END, out_last_r)
  // issuing the end record empties the line
  `LEFT_ASSERT_NXT(a_end_clears, clk, rst_n, state_r == ST_END && out_free,
                   wr_idx_r == '0 && state_r == ST_IDLE)

endmodule
